### rtl/sliding_window_k_smallest_sum_min_unit_macros.svh
// Assertion macros for the sliding-window k-smallest-sum unit.
// Used by the top level only; no dependencies.
`ifndef SLIDING_WINDOW_K_SMALLEST_SUM_MIN_UNIT_MACROS_SVH
`define SLIDING_WINDOW_K_SMALLEST_SUM_MIN_UNIT_MACROS_SVH
`ifndef SYNTH
`define SWKS_ASSERT_SAME(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |-> (b)) \
        else $error("assertion failed");
`define SWKS_ASSERT_NEXT(label, clk, rstn, a, b) \
    label: assert property (@(posedge clk) disable iff (!rstn) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define SWKS_ASSERT_SAME(label, clk, rstn, a, b)
`define SWKS_ASSERT_NEXT(label, clk, rstn, a, b)
`endif
`endif

### rtl/swks_pkg.sv
// Shared types and constants for the sliding-window k-smallest-sum unit.
// No dependencies.
package swks_pkg;

    localparam int WINDOW_MAX_DEF = 64;
    localparam int VALUE_BITS_DEF = 30;
    localparam int CFG_W          = 7;

    localparam logic CFG_IDX_K_COUNT    = 1'b0;
    localparam logic CFG_IDX_WINDOW_LEN = 1'b1;

    typedef struct packed {
        logic accept;
        logic evict;
        logic insert;
        logic sum_start;
        logic sum_step;
        logic score;
        logic emit;
    } swks_cmd_t;

    typedef struct packed {
        logic head_seen;
        logic need_evict;
        logic full_after;
        logic sum_done;
        logic last;
        logic best_valid;
        logic out_free;
    } swks_sts_t;

endpackage

### rtl/swks_ctrl.sv
// Controller state machine for the sliding-window k-smallest-sum unit.
// Depends on swks_pkg.
module swks_ctrl
    import swks_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  swks_sts_t sts,
    output swks_cmd_t cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_EVCHK  = 8'b0000_0010,
        S_EVICT  = 8'b0000_0100,
        S_INSERT = 8'b0000_1000,
        S_SUM    = 8'b0001_0000,
        S_SCORE  = 8'b0010_0000,
        S_FIN    = 8'b0100_0000,
        S_OUT    = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   final_reg, final_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        final_next = final_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = sts.head_seen ? S_EVCHK : S_FIN;
                end
            end
            S_EVCHK: begin
                state_next = sts.need_evict ? S_EVICT : S_INSERT;
            end
            S_EVICT: begin
                cmd.evict  = 1'b1;
                state_next = S_EVCHK;
            end
            S_INSERT: begin
                cmd.insert = 1'b1;
                if (sts.full_after) begin
                    cmd.sum_start = 1'b1;
                    final_next    = 1'b0;
                    state_next    = S_SUM;
                end else begin
                    state_next = S_FIN;
                end
            end
            S_SUM: begin
                if (sts.sum_done) begin
                    state_next = final_reg ? S_OUT : S_SCORE;
                end else begin
                    cmd.sum_step = 1'b1;
                end
            end
            S_SCORE: begin
                cmd.score  = 1'b1;
                state_next = S_FIN;
            end
            S_FIN: begin
                if (!sts.last) begin
                    state_next = S_IDLE;
                end else if (sts.best_valid) begin
                    state_next = S_OUT;
                end else begin
                    cmd.sum_start = 1'b1;
                    final_next    = 1'b1;
                    state_next    = S_SUM;
                end
            end
            S_OUT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            final_reg <= final_next;
        end
    end

endmodule

### rtl/swks_dp.sv
// Datapath: window ring memory, sorted cell chain, sum accumulator, output register.
// Depends on swks_pkg.
module swks_dp
    import swks_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int IN_TW      = ((VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_TW     = ((VALUE_BITS + 7 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IN_TW-1:0]  s_tdata,
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata,
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  swks_cmd_t         cmd,
    output swks_sts_t         sts
);

    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int IDX_W  = $clog2(WINDOW_MAX);
    localparam int SUM_W  = VALUE_BITS + IDX_W + 1;
    localparam int OUT_W  = VALUE_BITS + 7;
    localparam int TOT_W  = OUT_W + SUM_W;

    logic [CFG_W-1:0]      k_count_reg, window_len_reg;
    logic [VALUE_BITS-1:0] v_reg, head_reg, ring_rd_reg;
    logic                  last_reg, head_seen_reg, best_valid_reg, m_valid_reg;
    logic [FILL_W-1:0]     fill_reg, idx_reg, eff_w;
    logic [IDX_W-1:0]      start_reg, start_inc, wr_addr;
    logic [FILL_W:0]       wr_sum;
    logic [SUM_W-1:0]      acc_reg, best_reg, pick_sum;
    logic [OUT_W-1:0]      out_reg;
    logic [TOT_W-1:0]      total;

    logic [VALUE_BITS-1:0] ring_mem [WINDOW_MAX];
    logic [VALUE_BITS-1:0] cell_reg [WINDOW_MAX];
    logic [VALUE_BITS-1:0] cell_rm [WINDOW_MAX];
    logic [VALUE_BITS-1:0] cell_ins [WINDOW_MAX];
    logic [WINDOW_MAX-1:0] gt;

    always_comb begin
        if (window_len_reg == '0) begin
            eff_w = FILL_W'(1);
        end else if (32'(window_len_reg) > WINDOW_MAX) begin
            eff_w = FILL_W'(WINDOW_MAX);
        end else begin
            eff_w = FILL_W'(window_len_reg);
        end
    end

    assign sts.head_seen  = head_seen_reg;
    assign sts.need_evict = (fill_reg >= eff_w);
    assign sts.full_after = ((32'(fill_reg) + 1) == 32'(eff_w));
    assign sts.sum_done   = (32'(idx_reg) >= 32'(fill_reg)) ||
                            (32'(idx_reg) >= 32'(k_count_reg));
    assign sts.last       = last_reg;
    assign sts.best_valid = best_valid_reg;
    assign sts.out_free   = !m_valid_reg || m_tready;

    // ring addressing
    assign wr_sum    = (FILL_W+1)'(start_reg) + (FILL_W+1)'(fill_reg);
    assign wr_addr   = (32'(wr_sum) >= WINDOW_MAX) ? IDX_W'(32'(wr_sum) - WINDOW_MAX)
                                                   : IDX_W'(wr_sum);
    assign start_inc = (start_reg == IDX_W'(WINDOW_MAX - 1)) ? '0 : start_reg + 1'b1;

    always_ff @(posedge aclk) begin
        if (cmd.insert) begin
            ring_mem[wr_addr] <= v_reg;
        end
        ring_rd_reg <= ring_mem[start_reg];
    end

    // sorted chain: local shift left on removal, right on insertion
    genvar g;
    generate
        for (g = 0; g < WINDOW_MAX; g++) begin : g_cell
            assign gt[g] = (FILL_W'(g) < fill_reg) && (cell_reg[g] > v_reg);
            if (g == WINDOW_MAX - 1) begin : g_end
                assign cell_rm[g] = cell_reg[g];
            end else begin : g_mid
                assign cell_rm[g] = (cell_reg[g] >= ring_rd_reg) ? cell_reg[g+1] : cell_reg[g];
            end
            if (g == 0) begin : g_first
                assign cell_ins[g] = (gt[g] || fill_reg == FILL_W'(g)) ? v_reg : cell_reg[g];
            end else begin : g_rest
                assign cell_ins[g] = gt[g-1] ? cell_reg[g-1] :
                                     (gt[g] || fill_reg == FILL_W'(g)) ? v_reg : cell_reg[g];
            end
        end
    endgenerate

    always_ff @(posedge aclk) begin
        for (int j = 0; j < WINDOW_MAX; j++) begin
            if (cmd.evict) begin
                cell_reg[j] <= cell_rm[j];
            end else if (cmd.insert) begin
                cell_reg[j] <= cell_ins[j];
            end
        end
    end

    assign pick_sum = best_valid_reg ? best_reg : acc_reg;
    assign total    = TOT_W'(head_reg) + TOT_W'(pick_sum);

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            v_reg    <= s_tdata[VALUE_BITS-1:0];
            last_reg <= s_tlast;
        end
        if (cmd.accept && !head_seen_reg) begin
            head_reg <= s_tdata[VALUE_BITS-1:0];
        end
        if (cmd.sum_start) begin
            acc_reg <= '0;
        end else if (cmd.sum_step) begin
            acc_reg <= acc_reg + SUM_W'(cell_reg[idx_reg[IDX_W-1:0]]);
        end
        if (cmd.score && (!best_valid_reg || acc_reg < best_reg)) begin
            best_reg <= acc_reg;
        end
        if (cmd.emit) begin
            out_reg <= total[OUT_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_count_reg    <= CFG_W'(1);
            window_len_reg <= CFG_W'(1);
            fill_reg       <= '0;
            start_reg      <= '0;
            idx_reg        <= '0;
            head_seen_reg  <= 1'b0;
            best_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_wr_en && cfg_index == CFG_IDX_K_COUNT) begin
                k_count_reg <= cfg_wdata;
            end
            if (cfg_wr_en && cfg_index == CFG_IDX_WINDOW_LEN) begin
                window_len_reg <= cfg_wdata;
            end
            if (cmd.accept) begin
                head_seen_reg <= 1'b1;
            end
            if (cmd.evict) begin
                start_reg <= start_inc;
                fill_reg  <= fill_reg - 1'b1;
            end else if (cmd.insert) begin
                fill_reg <= fill_reg + 1'b1;
            end
            if (cmd.sum_start) begin
                idx_reg <= '0;
            end else if (cmd.sum_step) begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.score) begin
                best_valid_reg <= 1'b1;
            end
            if (cmd.emit) begin
                m_valid_reg    <= 1'b1;
                fill_reg       <= '0;
                start_reg      <= '0;
                head_seen_reg  <= 1'b0;
                best_valid_reg <= 1'b0;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = OUT_TW'(out_reg);

endmodule

### rtl/sliding_window_k_smallest_sum_min_unit.sv
// Sliding-window k-smallest-sum minimum unit, top level.
// Head item: accept, finish. Later item: accept, evict check, an evict per evicted value,
// insert, and if a window fills a sum walk over the sorted chain (one cell a cycle, k capped
// at fill) and score. Last item: sum walk if none filled, output; result valid the cycle after.
// One item in flight; the output register lets the next item start while a result waits.
// Reset: synchronous, active low; k_count and window_len return to 1, stream state clears.
`include "sliding_window_k_smallest_sum_min_unit_macros.svh"
module sliding_window_k_smallest_sum_min_unit
    import swks_pkg::*;
#(
    parameter int WINDOW_MAX = WINDOW_MAX_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    parameter int IN_TW      = ((VALUE_BITS + 7) / 8) * 8,
    parameter int OUT_TW     = ((VALUE_BITS + 7 + 7) / 8) * 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_TW-1:0]  s_tdata,   // value
    input  logic              s_tlast,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_TW-1:0] m_tdata,   // min_cost
    input  logic              cfg_wr_en,
    input  logic              cfg_index,
    input  logic [CFG_W-1:0]  cfg_wdata
);

    swks_cmd_t cmd;
    swks_sts_t sts;

    swks_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    swks_dp #(
        .WINDOW_MAX (WINDOW_MAX),
        .VALUE_BITS (VALUE_BITS),
        .IN_TW      (IN_TW),
        .OUT_TW     (OUT_TW)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts)
    );

    `SWKS_ASSERT_NEXT(a_one_item, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    `SWKS_ASSERT_SAME(a_emit_free, aclk, aresetn, cmd.emit, sts.out_free)
    `SWKS_ASSERT_NEXT(a_emit_valid, aclk, aresetn, cmd.emit, m_tvalid)

endmodule
